// File: src/rchd_pkg.sv
// shared types, constants and the hash step for the region change detector
package rchd_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [10:0] PIC_WIDTH_RESET  = 11'd640;
    localparam logic [10:0] PIC_HEIGHT_RESET = 11'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIC_WIDTH  = 3'd0,
        REG_PIC_HEIGHT = 3'd1,
        REG_ROI_LEFT   = 3'd2,
        REG_ROI_TOP    = 3'd3,
        REG_ROI_COLS   = 3'd4,
        REG_ROI_ROWS   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_BYTE   = 1'b0,
        CMD_COMMIT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_REGION = 2'd1,
        STATUS_SHORT      = 2'd2
    } status_t;

    typedef struct packed {
        logic [10:0] pic_width;
        logic [10:0] pic_height;
        logic [9:0]  roi_left;
        logic [9:0]  roi_top;
        logic [10:0] roi_cols;
        logic [10:0] roi_rows;
    } cfg_t;

    // per-word control from the raster scanner to the hash unit
    typedef struct packed {
        logic    hash_en;
        logic    frame_done;
        status_t status;
    } scan_info_t;

    // one fnv-1a step, prime multiply as shift and add
    function automatic logic [31:0] fnv_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = acc ^ {24'd0, b};
            fnv_step = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

// File: src/rchd_scan.sv
// raster position counters, region window test and frame status
module rchd_scan #(
    parameter int MAX_DIM = rchd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                frame_end,
    input  rchd_pkg::cfg_t      cfg,
    output rchd_pkg::scan_info_t info
);

    localparam int BCW = $clog2(2 * MAX_DIM);
    localparam int RW  = $clog2(MAX_DIM + 1);
    localparam int CW  = (BCW + 2 > 14) ? BCW + 2 : 14;

    logic [BCW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           filled_reg, filled_next;

    logic [CW-1:0] fw, fh, left, top, cols, rows;
    logic [CW-1:0] col_e, col_inc, row_e, row_inc, row_bytes;
    logic          dims_valid, fits, take, in_window, wrap, filled_after;

    always_comb begin
        fw   = CW'(cfg.pic_width);
        fh   = CW'(cfg.pic_height);
        left = CW'(cfg.roi_left);
        top  = CW'(cfg.roi_top);
        cols = CW'(cfg.roi_cols);
        rows = CW'(cfg.roi_rows);

        dims_valid = (fw != '0) && (fw <= CW'(MAX_DIM)) &&
                     (fh != '0) && (fh <= CW'(MAX_DIM));
        fits = dims_valid && (cols != '0) && (rows != '0) &&
               (left + cols <= fw) && (top + rows <= fh);

        col_e     = CW'(col_reg);
        row_e     = CW'(row_reg);
        col_inc   = col_e + CW'(1);
        row_inc   = row_e + CW'(1);
        row_bytes = fw << 1;

        take      = !filled_reg && dims_valid;
        in_window = take &&
                    (row_e >= top) && (row_e < top + rows) &&
                    (col_e >= (left << 1)) && (col_e < ((left + cols) << 1));
        wrap      = col_inc >= row_bytes;
        filled_after = filled_reg || (take && wrap && (row_inc >= fh));

        info.hash_en    = step && in_window;
        info.frame_done = step && frame_end;
        if (!fits) begin
            info.status = rchd_pkg::STATUS_BAD_REGION;
        end else if (!filled_after) begin
            info.status = rchd_pkg::STATUS_SHORT;
        end else begin
            info.status = rchd_pkg::STATUS_OK;
        end

        col_next    = col_reg;
        row_next    = row_reg;
        filled_next = filled_reg;
        if (step) begin
            if (frame_end) begin
                col_next    = '0;
                row_next    = '0;
                filled_next = 1'b0;
            end else if (take) begin
                filled_next = filled_after;
                if (wrap) begin
                    col_next = '0;
                    row_next = row_inc[RW-1:0];
                end else begin
                    col_next = col_inc[BCW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            filled_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            filled_reg <= filled_next;
        end
    end

endmodule

// File: src/rchd_hash.sv
// fnv-1a accumulator with latest and committed hash
module rchd_hash (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rchd_pkg::scan_info_t info,
    input  logic                 commit,
    input  logic [7:0]           pixel_byte,
    output logic [31:0]          region_hash,
    output logic                 changed
);

    logic [31:0] acc_reg, acc_next;
    logic [31:0] latest_reg, latest_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] acc_upd;
    logic        ok;

    always_comb begin
        acc_upd = info.hash_en ? rchd_pkg::fnv_step(acc_reg, pixel_byte) : acc_reg;
        ok      = info.status == rchd_pkg::STATUS_OK;

        region_hash = ok ? acc_upd : 32'd0;
        changed     = ok && (acc_upd != last_reg);

        acc_next    = acc_upd;
        latest_next = latest_reg;
        last_next   = last_reg;
        if (info.frame_done) begin
            acc_next = rchd_pkg::FNV_BASIS;
            if (ok) begin
                latest_next = acc_upd;
            end
        end
        if (commit) begin
            last_next = latest_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= rchd_pkg::FNV_BASIS;
            latest_reg <= '0;
            last_reg   <= '0;
        end else begin
            acc_reg    <= acc_next;
            latest_reg <= latest_next;
            last_reg   <= last_next;
        end
    end

endmodule

// File: src/roi_crop_hash_change_detector.sv
// top level: region of interest fnv-1a change detector over a byte stream
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    s_cmd, s_pixel_byte, s_frame_end
//  m_        out   m_valid/m_ready    m_status, m_region_hash, m_changed
//  cfg_      in    cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while results are read; a word is held in the
// input register, is processed against the scan and hash state, and a result
// lands in the output register. the word rate rests on the hash feedback loop
// (xor plus constant multiply) being combinational.
// synchronous active-low reset restores the config defaults and clears the
// counters; no clearing pass. a frame-end word waits in the input register
// only while an earlier result is still unread; other words never wait.
module roi_crop_hash_change_detector #(
    parameter int MAX_DIM = rchd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [7:0]                      s_pixel_byte,
    input  logic                            s_frame_end,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [31:0]                     m_region_hash,
    output logic                            m_changed,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rchd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rchd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    rchd_pkg::cfg_t cfg_reg, cfg_next;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg;
    logic [31:0] m_hash_reg;
    logic        m_changed_reg;

    logic fire, is_byte, needs_out, step, commit, s_take;

    rchd_pkg::scan_info_t info;
    logic [31:0]          hash_val;
    logic                 changed_val;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (rchd_pkg::cfg_index_t'(cfg_index))
                rchd_pkg::REG_PIC_WIDTH:  cfg_next.pic_width  = cfg_data;
                rchd_pkg::REG_PIC_HEIGHT: cfg_next.pic_height = cfg_data;
                rchd_pkg::REG_ROI_LEFT:   cfg_next.roi_left   = cfg_data[9:0];
                rchd_pkg::REG_ROI_TOP:    cfg_next.roi_top    = cfg_data[9:0];
                rchd_pkg::REG_ROI_COLS:   cfg_next.roi_cols   = cfg_data;
                rchd_pkg::REG_ROI_ROWS:   cfg_next.roi_rows   = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // a frame-end byte needs room in the output register, all else moves freely
    always_comb begin
        is_byte   = in_cmd_reg == rchd_pkg::CMD_BYTE;
        needs_out = is_byte && in_end_reg;
        fire      = in_valid_reg && (!needs_out || !m_valid_reg || m_ready);
        step      = fire && is_byte;
        commit    = fire && !is_byte;
        s_ready   = !in_valid_reg || fire;
        s_take    = s_valid && s_ready;

        in_valid_next = s_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

        if (fire && needs_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    rchd_scan #(
        .MAX_DIM(MAX_DIM)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .frame_end (in_end_reg),
        .cfg       (cfg_reg),
        .info      (info)
    );

    rchd_hash u_hash (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .info        (info),
        .commit      (commit),
        .pixel_byte  (in_byte_reg),
        .region_hash (hash_val),
        .changed     (changed_val)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pic_width    <= rchd_pkg::PIC_WIDTH_RESET;
            cfg_reg.pic_height   <= rchd_pkg::PIC_HEIGHT_RESET;
            cfg_reg.roi_left     <= '0;
            cfg_reg.roi_top      <= '0;
            cfg_reg.roi_cols     <= '0;
            cfg_reg.roi_rows     <= '0;
            in_valid_reg         <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_pixel_byte;
            in_end_reg  <= s_frame_end;
        end
        if (fire && needs_out) begin
            m_status_reg  <= info.status;
            m_hash_reg    <= hash_val;
            m_changed_reg <= changed_val;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_region_hash = m_hash_reg;
    assign m_changed     = m_changed_reg;

`ifndef NO_ASSERTIONS
    // a change is only flagged on a good frame
    a_changed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_changed || m_status == rchd_pkg::STATUS_OK))
        else $error("changed flag set on a bad frame");

    // a bad frame reports a zero hash
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != rchd_pkg::STATUS_OK) |-> (m_region_hash == 32'd0))
        else $error("nonzero hash on a bad frame");

    // input backs up only behind an unread result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without an output stall");

    // a result never appears without a frame-end word going through
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(fire && needs_out))
        else $error("result without a frame-end word");
`endif

endmodule
